FILE: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Field widths of the request and result transactions.
  localparam int FRAME_W = 12;
  localparam int CNT_W   = 13;
  localparam int STAT_W  = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAMES_DEF    = 4096;
  localparam int MAP_WORD_BITS_DEF = 32;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUT_RNG  = 2'd2;

  // Request payload.
  typedef struct packed {
    logic               func;
    logic [FRAME_W-1:0] frame_index;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   free_frames;
    logic [CNT_W-1:0]   total_frames;
  } out_t;

endpackage

FILE: rtl/core/bfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a used-bit map held in a RAM.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      request    in_valid / in_ready    bfa_pkg::in_t  (func, frame_index)
//  out_     result     out_valid / out_ready  bfa_pkg::out_t (frame, status, counts)
//  cfg_     config     cfg_valid / cfg_ready  frame_count, 13 bits
//
// A request walks the map one word at a time (RAM read, then check and write
// back), from word 0 up to the word that holds a free bit (allocate), the
// requested index (free) or the last managed frame (allocate, none free).
// An out-of-range free or an allocate with no frames managed skips the walk.
// Reset clears the map through per-word valid flags, so no clearing pass runs.
// One finished result is held in the output register; a new request is
// accepted while it waits, and the next result waits until it is taken.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES    = bfa_pkg::MAX_FRAMES_DEF,
  parameter int MAP_WORD_BITS = bfa_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bfa_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bfa_pkg::out_t            out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bfa_pkg::CNT_W-1:0] cfg_data
);

  import bfa_pkg::*;

  localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int BASE_W    = CNT_W + 1;
  localparam int MAX_LIM_I = (MAX_FRAMES > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : MAX_FRAMES;
  localparam logic [CNT_W-1:0]  MAX_LIM   = CNT_W'(MAX_LIM_I);
  localparam logic [BASE_W-1:0] WORD_STEP = BASE_W'(MAP_WORD_BITS);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]               state_r,      state_nxt;
  logic                     func_r,       func_nxt;
  logic [FRAME_W-1:0]       idx_r,        idx_nxt;
  logic [WORD_AW-1:0]       word_r,       word_nxt;
  logic [BASE_W-1:0]        base_r,       base_nxt;
  logic [FRAME_W-1:0]       res_frame_r,  res_frame_nxt;
  logic [STAT_W-1:0]        res_status_r, res_status_nxt;
  logic [CNT_W-1:0]         used_r,       used_nxt;
  logic [CNT_W-1:0]         cnt_cfg_r,    cnt_cfg_nxt;
  logic [MAP_WORDS-1:0]     row_vld_r,    row_vld_nxt;
  logic                     out_valid_r,  out_valid_nxt;
  out_t                     out_data_r,   out_data_nxt;

  logic [CNT_W-1:0]         eff_cnt;
  logic [BASE_W-1:0]        cnt_ext;
  logic [MAP_WORD_BITS-1:0] ram_rdata;
  logic [MAP_WORD_BITS-1:0] map_word;
  logic [MAP_WORD_BITS-1:0] bit_mask;
  logic [MAP_WORD_BITS-1:0] wr_word;
  logic                     ram_we;
  logic                     ram_re;
  logic                     zfound;
  logic [BIT_W-1:0]         zbit;
  logic [BASE_W-1:0]        alloc_f;
  logic [BASE_W-1:0]        diff;
  logic                     free_hit;
  logic [BIT_W-1:0]         fbit;
  logic [BIT_W-1:0]         sel_bit;
  logic [BASE_W-1:0]        base_adv;

  // Effective frame count, saturated at the map size.
  assign eff_cnt = (cnt_cfg_r > MAX_LIM) ? MAX_LIM : cnt_cfg_r;
  assign cnt_ext = {1'b0, eff_cnt};

  // Used-bit map storage.
  bfa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r),
    .wdata (wr_word),
    .re    (ram_re),
    .raddr (word_r),
    .rdata (ram_rdata)
  );

  // A word never written since reset reads as all free.
  assign map_word = row_vld_r[word_r] ? ram_rdata : '0;

  // Lowest free bit of the current word.
  always_comb begin
    zfound = 1'b0;
    zbit   = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!map_word[i]) begin
        zfound = 1'b1;
        zbit   = BIT_W'(i);
      end
    end
  end

  // Frame arithmetic shared by the scan: candidate frame, offset and next base.
  assign alloc_f  = base_r + BASE_W'(zbit);
  assign diff     = BASE_W'(idx_r) - base_r;
  assign free_hit = (diff < WORD_STEP);
  assign fbit     = diff[BIT_W-1:0];
  assign base_adv = base_r + WORD_STEP;

  // Write-back word: set the allocated bit or clear the freed one.
  assign sel_bit  = (func_r == FUNC_FREE) ? fbit : zbit;
  assign bit_mask = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << sel_bit;
  assign wr_word  = (func_r == FUNC_FREE) ? (map_word & ~bit_mask) : (map_word | bit_mask);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    base_nxt       = base_r;
    res_frame_nxt  = res_frame_r;
    res_status_nxt = res_status_r;
    used_nxt       = used_r;
    cnt_cfg_nxt    = cnt_cfg_r;
    row_vld_nxt    = row_vld_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (cfg_valid) begin
      cnt_cfg_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_data.func;
          idx_nxt  = in_data.frame_index;
          word_nxt = '0;
          base_nxt = '0;
          if (in_data.func == FUNC_FREE && {1'b0, in_data.frame_index} >= eff_cnt) begin
            res_frame_nxt  = in_data.frame_index;
            res_status_nxt = STAT_OUT_RNG;
            state_nxt      = S_DONE;
          end else if (in_data.func == FUNC_ALLOC && eff_cnt == '0) begin
            res_frame_nxt  = '0;
            res_status_nxt = STAT_NO_FREE;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (func_r == FUNC_ALLOC) begin
          if (zfound && alloc_f < cnt_ext) begin
            ram_we              = 1'b1;
            row_vld_nxt[word_r] = 1'b1;
            used_nxt            = used_r + CNT_W'(1);
            res_frame_nxt       = alloc_f[FRAME_W-1:0];
            res_status_nxt      = STAT_OK;
            state_nxt           = S_DONE;
          end else if (zfound || base_adv >= cnt_ext) begin
            res_frame_nxt  = '0;
            res_status_nxt = STAT_NO_FREE;
            state_nxt      = S_DONE;
          end else begin
            base_nxt  = base_adv;
            word_nxt  = word_r + WORD_AW'(1);
            state_nxt = S_READ;
          end
        end else begin
          if (free_hit) begin
            if (map_word[fbit]) begin
              ram_we              = 1'b1;
              row_vld_nxt[word_r] = 1'b1;
              if (used_r != '0) begin
                used_nxt = used_r - CNT_W'(1);
              end
            end
            res_frame_nxt  = idx_r;
            res_status_nxt = STAT_OK;
            state_nxt      = S_DONE;
          end else begin
            base_nxt  = base_adv;
            word_nxt  = word_r + WORD_AW'(1);
            state_nxt = S_READ;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.frame        = res_frame_r;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.free_frames  = (eff_cnt > used_r) ? (eff_cnt - used_r) : '0;
          out_data_nxt.total_frames = eff_cnt;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cnt_cfg_r   <= MAX_LIM;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cnt_cfg_r   <= cnt_cfg_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    idx_r        <= idx_nxt;
    word_r       <= word_nxt;
    base_r       <= base_nxt;
    res_frame_r  <= res_frame_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

FILE: dv/bitmap_frame_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_test
// Self-checking testbench for the first-fit page frame allocator. A ledger
// class keeps its own used-bit map, used count and frame count, predicts the
// reply to every accepted request and checks each returned reply in order.
// Directed requests cover the corner cases, then randomized phases run under
// a range of frame counts, with random gaps on the request side and random
// stalls on the reply side.
// ----------------------------------------------------------------------------

// Ledger of the allocator state: predicts replies and checks the ones that come
// back, oldest first.
class frame_ledger;

  bit                               used_bits [bfa_pkg::MAX_FRAMES_DEF];
  int unsigned                      used_total;
  logic [bfa_pkg::CNT_W-1:0]        count_reg;
  bfa_pkg::out_t                    replies_due [$];
  int                               errors;
  int                               replies_seen;
  int                               grants;
  int                               refusals;
  int                               frees;
  int                               range_misses;

  function new();
    foreach (used_bits[i]) used_bits[i] = 1'b0;
    used_total   = 0;
    count_reg    = bfa_pkg::CNT_W'(bfa_pkg::MAX_FRAMES_DEF);
    errors       = 0;
    replies_seen = 0;
    grants       = 0;
    refusals     = 0;
    frees        = 0;
    range_misses = 0;
  endfunction

  // A count above the map size is clipped to the map size.
  function int unsigned managed_frames();
    if (count_reg > bfa_pkg::MAX_FRAMES_DEF) return bfa_pkg::MAX_FRAMES_DEF;
    return count_reg;
  endfunction

  function void set_frame_count(logic [bfa_pkg::CNT_W-1:0] value);
    count_reg = value;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  // Apply one accepted request to the ledger and queue the reply it owes.
  function void note_request(bfa_pkg::in_t req);
    bfa_pkg::out_t want;
    int unsigned   lim;
    int            f;
    lim         = managed_frames();
    want.frame  = '0;
    want.status = bfa_pkg::STAT_OK;
    if (req.func == bfa_pkg::FUNC_ALLOC) begin
      want.status = bfa_pkg::STAT_NO_FREE;
      for (f = 0; f < lim; f++) begin
        if (!used_bits[f]) begin
          used_bits[f] = 1'b1;
          used_total++;
          want.frame  = f[bfa_pkg::FRAME_W-1:0];
          want.status = bfa_pkg::STAT_OK;
          break;
        end
      end
      if (want.status == bfa_pkg::STAT_OK) grants++;
      else refusals++;
    end else begin
      want.frame = req.frame_index;
      frees++;
      if (req.frame_index >= lim) begin
        want.status = bfa_pkg::STAT_OUT_RNG;
        range_misses++;
      end else if (used_bits[req.frame_index]) begin
        used_bits[req.frame_index] = 1'b0;
        if (used_total > 0) used_total--;
      end
    end
    want.free_frames  = (lim > used_total) ? bfa_pkg::CNT_W'(lim - used_total) : '0;
    want.total_frames = bfa_pkg::CNT_W'(lim);
    replies_due.push_back(want);
  endfunction

  // One line per mismatch, and every one is counted.
  task report_mismatch(string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Compare a returned reply, field by field, with the oldest one owed.
  task check_result(bfa_pkg::out_t got);
    bfa_pkg::out_t want;
    if (replies_due.size() == 0) begin
      report_mismatch($sformatf("reply with none owed: frame %0d status %0d",
                                got.frame, got.status));
      return;
    end
    want = replies_due.pop_front();
    replies_seen++;
    if (got.frame !== want.frame)
      report_mismatch($sformatf("reply %0d frame %0d, expected %0d",
                                replies_seen, got.frame, want.frame));
    if (got.status !== want.status)
      report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                replies_seen, got.status, want.status));
    if (got.free_frames !== want.free_frames)
      report_mismatch($sformatf("reply %0d free_frames %0d, expected %0d",
                                replies_seen, got.free_frames, want.free_frames));
    if (got.total_frames !== want.total_frames)
      report_mismatch($sformatf("reply %0d total_frames %0d, expected %0d",
                                replies_seen, got.total_frames, want.total_frames));
  endtask

endclass

module bitmap_frame_allocator_test;
  import bfa_pkg::*;

  typedef struct {
    int count;
    int items;
    int alloc_pct;
    bit steady;
  } phase_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  frame_ledger      book;
  phase_t           plan [$];
  int               requests_sent;
  int               cfg_writes;

  bitmap_frame_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every reply transaction as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_data);
  end

  // Reply side: bursts of ready broken by stalls, mostly short and a few long.
  initial begin : reply_pacing
    int run_len;
    int stall_len;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(99) < 90) ? $urandom_range(20, 1) : $urandom_range(150, 60);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = $urandom_range(99);
      if (stall_len < 50) stall_len = 0;
      else if (stall_len < 85) stall_len = $urandom_range(3, 1);
      else stall_len = $urandom_range(40, 10);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("bitmap_frame_allocator_test NOT OK");
    $finish;
  end

  // Present one request and hold it until the allocator takes it.
  task automatic send_request(input in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_request(req);
    requests_sent++;
  endtask

  task automatic send_op(input logic func, input int idx);
    in_t req;
    req.func        = func;
    req.frame_index = idx[FRAME_W-1:0];
    send_request(req);
  endtask

  // Stop sending and let every owed reply come back, plus a short margin.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write frame_count while the allocator is idle.
  task automatic write_frame_count(input logic [CNT_W-1:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    book.set_frame_count(value);
    cfg_writes++;
  endtask

  // Request gap: mostly none or short, now and then long.
  function automatic int sender_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Frees mostly aim at the low, first-fit region where used frames sit, so
  // they usually release a real frame; the rest land anywhere in range or
  // anywhere in the index space.
  function automatic in_t pick_request(input int alloc_pct);
    in_t          req;
    logic [31:0]  bits;
    int unsigned  span;
    int unsigned  roll;
    bits = $urandom;
    req.frame_index = bits[FRAME_W-1:0];
    req.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
    if (req.func == FUNC_FREE) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        span = book.used_total + 3;
        if (span > 4095) span = 4095;
        req.frame_index = FRAME_W'($urandom_range(span));
      end else if (roll < 90 && book.managed_frames() > 0) begin
        req.frame_index = FRAME_W'($urandom_range(book.managed_frames() - 1));
      end
    end
    return req;
  endfunction

  initial begin : stimulus
    int p;
    int k;
    int gap;
    book          = new();
    requests_sent = 0;
    cfg_writes    = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first fit, freeing a free frame, top and bottom indexes.
    send_op(FUNC_ALLOC, 4095);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_FREE, 1);
    send_op(FUNC_FREE, 1);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_FREE, 4095);
    send_op(FUNC_FREE, 0);
    send_op(FUNC_ALLOC, 0);

    // Zero frames managed: allocation refused, every free out of range.
    write_frame_count('0);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_FREE, 0);
    send_op(FUNC_FREE, 4095);

    // Oversized count clips to the map size.
    write_frame_count('1);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_FREE, 4095);

    // One frame managed while higher frames are still in use.
    write_frame_count(CNT_W'(1));
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_FREE, 0);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_ALLOC, 0);
    send_op(FUNC_FREE, 1);
    send_op(FUNC_FREE, 2);
    write_frame_count(CNT_W'(MAX_FRAMES_DEF));
    send_op(FUNC_FREE, 3);

    // Random phases over a spread of frame counts.
    plan.push_back('{64,   150, 75, 1'b0});
    plan.push_back('{4096, 300, 90, 1'b1});
    plan.push_back('{100,  100, 50, 1'b0});
    plan.push_back('{33,    80, 60, 1'b0});
    plan.push_back('{1,     40, 50, 1'b1});
    plan.push_back('{8191, 150, 40, 1'b0});
    plan.push_back('{0,     20, 50, 1'b0});
    plan.push_back('{300,  250, 85, 1'b0});
    plan.push_back('{5000, 100, 30, 1'b1});
    plan.push_back('{2,     40, 60, 1'b0});
    plan.push_back('{4095, 200, 70, 1'b0});
    plan.push_back('{4096, 150, 20, 1'b0});
    plan.push_back('{17,    60, 55, 1'b1});
    plan.push_back('{1000, 100, 50, 1'b0});

    for (p = 0; p < plan.size(); p++) begin
      write_frame_count(CNT_W'(plan[p].count));
      for (k = 0; k < plan[p].items; k++) begin
        // Halfway through, hold off until the allocator has answered everything.
        if (k == plan[p].items / 2) settle_block();
        send_request(pick_request(plan[p].alloc_pct));
        if (!plan[p].steady) begin
          gap = sender_gap();
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    settle_block();
    repeat (20) @(posedge clk);
    if (book.pending() != 0)
      book.report_mismatch($sformatf("%0d replies never arrived", book.pending()));

    $display("Sent %0d requests across %0d frame-count writes, counts 0 through 8191.",
             requests_sent, cfg_writes);
    $display("Allocations granted %0d, refused %0d; frees %0d, of them %0d out of range.",
             book.grants, book.refusals, book.frees, book.range_misses);
    if (book.errors == 0) begin
      $display("bitmap_frame_allocator_test OK");
    end else begin
      $display("bitmap_frame_allocator_test NOT OK");
    end
    $finish;
  end

endmodule
